// ===== rtl/acoustic_fix_to_cartesian_assert.svh =====
// Assertion macros for the acoustic fix block.
// The property is checked on the rising edge of clk; ACF_ASSERT is off while rst is high.
`ifndef ACOUSTIC_FIX_TO_CARTESIAN_ASSERT_SVH
`define ACOUSTIC_FIX_TO_CARTESIAN_ASSERT_SVH

`ifndef ASSERT_OFF
`define ACF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ACF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACF_ASSERT(lbl, prop, msg)
`define ACF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/acf_pkg.sv =====
`timescale 1ns / 1ps

package acf_pkg;

  // default parameter values
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STEPS_DEF    = 16;

  // item kinds
  localparam logic [1:0] MODE_DEPTH = 2'd0;
  localparam logic [1:0] MODE_ANGLE = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;

  // register file
  localparam int         APB_ADDR_W      = 2;
  localparam logic [1:0] REG_DEPTH_FLOOR = 2'd0;

  // reset values
  localparam logic [15:0]        DEPTH_FLOOR_RST = 16'd100;
  localparam logic signed [23:0] DEPTH_RST       = 24'sd1000;
  localparam logic [31:0]        DVAR_RST        = 32'd100000;

  // angle constants, Q30 radians
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = 24'sh800000;

  // atan(2^-k) in Q30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RED, S_FOLD, S_ROT,
    S_NMUL, S_DMUL, S_DIVC, S_DIV,
    S_AXX, S_AXY, S_TA, S_TA2, S_TB, S_TB2, S_SQRT,
    S_OUT
  } acf_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] bearing;
    logic signed [15:0] elevation;
    logic [13:0]        angle_accuracy;
    logic signed [23:0] depth_mm;
    logic [31:0]        depth_variance;
    logic signed [23:0] north;
    logic signed [23:0] east;
    logic signed [23:0] up;
    logic [15:0]        range_accuracy;
  } acf_in_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [31:0]        spread_x;
    logic [31:0]        spread_y;
    logic [31:0]        spread_z;
    logic               saturated;
    logic               source;
  } acf_out_t;

endpackage

// ===== rtl/acf_if.sv =====
`timescale 1ns / 1ps

// fix channel
interface acf_fix_if import acf_pkg::*;;
  logic    valid;
  logic    ready;
  acf_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface acf_result_if import acf_pkg::*;;
  logic     valid;
  logic     ready;
  acf_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/acoustic_fix_to_cartesian.sv =====
`timescale 1ns / 1ps
// Depth update: depth and variance are registered as the item is accepted.
// A range fix goes through the output state to the result register. An angle
// fix steps through angle reduction by 2*pi, the shared CORDIC stage, the single
// multiplier, the one-bit-a-cycle divider (cut short for a coordinate that
// saturates at divider setup) and the one-bit-a-cycle square root.
// Throughput: one transaction at a time; fix.ready is high only when idle.
// Reset (rst, synchronous): depth floor 100, depth 1000, variance 100000, idle.
`include "acoustic_fix_to_cartesian_assert.svh"

module acoustic_fix_to_cartesian import acf_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  acf_fix_if.sink               fix,
  acf_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int SHIFT  = 30 - ANGLE_FRAC_BITS;
  localparam int AW     = (47 - ANGLE_FRAC_BITS > 34) ? 48 - ANGLE_FRAC_BITS : 35;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  localparam logic signed [AW-1:0] PI_W      = AW'(PI_Q30);
  localparam logic signed [AW-1:0] HALF_PI_W = AW'(HALF_PI_Q30);
  localparam logic signed [AW-1:0] TWO_PI_W  = AW'(TWO_PI_Q30);

  acf_state_t state, state_next;

  // held state and register
  logic [15:0]        depth_floor;
  logic signed [23:0] depth_held;
  logic [31:0]        dvar_held;

  // captured item
  logic signed [AW-1:0] b_w, e_w, acc_w;
  logic signed [23:0]   north_r, east_r, up_r;
  logic [15:0]          racc_r;
  logic                 rng_r;
  logic                 flag_r;

  // CORDIC
  logic [2:0]           ang_j;
  logic [STEP_W-1:0]    step_i;
  logic signed [AW-1:0] a_r;
  logic                 neg_r;
  logic signed [33:0]   cx, cy;
  logic signed [31:0]   sin_r [6];
  logic signed [31:0]   cos_r [6];

  // coordinates and divider
  logic [2:0]         fix_f;
  logic               co_r;
  logic signed [31:0] n_r;
  logic signed [55:0] num_r;
  logic [55:0]        rem, dsh;
  logic [24:0]        quo;
  logic [4:0]         div_cnt;
  logic               qneg;
  logic signed [23:0] xs [5];
  logic signed [23:0] ys [5];

  // axes, spreads, square root
  logic [1:0]         ph;
  logic signed [32:0] t_r;
  logic [63:0]        sq_r;
  logic [63:0]        sv, sr, sbit;
  logic [31:0]        ax_r [2];
  logic [31:0]        spr_r [2];

  logic     res_valid;
  acf_out_t res_data;

  // ---------------- combinational helpers ----------------
  logic accept, slot_free, cfg_wr, depth_ok;
  assign accept    = fix.valid && fix.ready;
  assign slot_free = !res_valid || result.ready;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr == REG_DEPTH_FLOOR);
  assign depth_ok  = depth_held >= $signed({8'd0, depth_floor});

  // angle for CORDIC run j
  logic signed [AW-1:0] ang_sel;
  always_comb begin
    case (ang_j)
      3'd0:    ang_sel = b_w;
      3'd1:    ang_sel = e_w;
      3'd2:    ang_sel = e_w + acc_w;
      3'd3:    ang_sel = e_w - acc_w;
      3'd4:    ang_sel = b_w + acc_w;
      3'd5:    ang_sel = b_w - acc_w;
      default: ang_sel = b_w;
    endcase
  end

  // CORDIC rotation step
  logic signed [33:0]   sh_x, sh_y, nx, ny;
  logic signed [AW-1:0] atan_w;
  logic                 rot_last, red_done;
  assign sh_x     = cx >>> step_i;
  assign sh_y     = cy >>> step_i;
  assign atan_w   = AW'($signed({1'b0, ATAN_Q30[5'(step_i)]}));
  assign nx       = (a_r >= 0) ? cx - sh_y : cx + sh_y;
  assign ny       = (a_r >= 0) ? cy + sh_x : cy - sh_x;
  assign rot_last = step_i == STEP_W'(CORDIC_STEPS - 1);
  assign red_done = (a_r <= PI_W) && (a_r > -PI_W);

  // trig of the current fix
  logic signed [31:0] tb_sin, tb_cos, te_sin, te_cos;
  always_comb begin
    case (fix_f)
      3'd3:    begin tb_sin = sin_r[4]; tb_cos = cos_r[4]; end
      3'd4:    begin tb_sin = sin_r[5]; tb_cos = cos_r[5]; end
      default: begin tb_sin = sin_r[0]; tb_cos = cos_r[0]; end
    endcase
    case (fix_f)
      3'd1:    begin te_sin = sin_r[2]; te_cos = cos_r[2]; end
      3'd2:    begin te_sin = sin_r[3]; te_cos = cos_r[3]; end
      default: begin te_sin = sin_r[1]; te_cos = cos_r[1]; end
    endcase
  end

  // axis differences and ordering
  logic signed [24:0] dx, dy;
  logic [31:0]        ax_big, ax_small;
  assign dx       = ph[0] ? 25'(xs[4]) - 25'(xs[3]) : 25'(xs[2]) - 25'(xs[1]);
  assign dy       = ph[0] ? 25'(ys[4]) - 25'(ys[3]) : 25'(ys[2]) - 25'(ys[1]);
  assign ax_big   = (ax_r[0] > ax_r[1]) ? ax_r[0] : ax_r[1];
  assign ax_small = (ax_r[0] > ax_r[1]) ? ax_r[1] : ax_r[0];

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  always_comb begin
    unique case (state)
      S_NMUL:  begin
        mul_a = 33'(co_r ? tb_cos : tb_sin);
        mul_b = 33'(te_cos);
      end
      S_DMUL:  begin mul_a = 33'(n_r); mul_b = 33'(depth_held); end
      S_AXX:   begin mul_a = 33'(dx); mul_b = 33'(dx); end
      S_AXY:   begin mul_a = 33'(dy); mul_b = 33'(dy); end
      S_TA:    begin
        mul_a = $signed({1'b0, ax_big});
        mul_b = 33'(ph[0] ? cos_r[0] : sin_r[0]);
      end
      S_TB:    begin
        mul_a = $signed({1'b0, ax_small});
        mul_b = 33'(ph[0] ? sin_r[0] : cos_r[0]);
      end
      S_TA2, S_TB2: begin mul_a = t_r; mul_b = t_r; end
      S_OUT:   begin mul_a = $signed({17'd0, racc_r}); mul_b = $signed({17'd0, racc_r}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // divider setup and step
  logic               num_neg, den_zero, div_ovf, div_ge, coord_done;
  logic [55:0]        num_abs;
  logic [31:0]        den_abs;
  logic [24:0]        q_fin;
  logic signed [23:0] coord_val;
  logic               coord_sat;
  assign num_neg  = num_r[55];
  assign num_abs  = num_neg ? 56'(-num_r) : 56'(num_r);
  assign den_abs  = te_sin[31] ? 32'(-te_sin) : 32'(te_sin);
  assign den_zero = te_sin == 32'sd0;
  assign div_ovf  = {1'b0, num_abs} >= {den_abs, 25'd0};
  assign div_ge   = rem >= dsh;
  assign q_fin    = {quo[23:0], div_ge};

  always_comb begin
    coord_val = '0;
    coord_sat = 1'b0;
    if (state == S_DIVC) begin
      if (den_zero) begin
        coord_sat = 1'b1;
        coord_val = (num_r == 56'sd0) ? 24'sd0 : (num_neg ? POS_MIN : POS_MAX);
      end else begin
        coord_sat = 1'b1;
        coord_val = (num_neg ^ te_sin[31]) ? POS_MIN : POS_MAX;
      end
    end else if (qneg) begin
      coord_sat = q_fin > 25'd8388608;
      coord_val = coord_sat ? POS_MIN : 24'(-$signed({1'b0, q_fin}));
    end else begin
      coord_sat = q_fin > 25'd8388607;
      coord_val = coord_sat ? POS_MAX : 24'(q_fin);
    end
  end
  assign coord_done = ((state == S_DIVC) && (den_zero || div_ovf)) ||
                      ((state == S_DIV) && (div_cnt == 5'd0));

  // square root step
  logic [63:0] s_trial, r_fin;
  logic        s_ge, sqrt_done;
  assign s_trial   = sr + sbit;
  assign s_ge      = sv >= s_trial;
  assign r_fin     = s_ge ? (sr >> 1) + sbit : sr >> 1;
  assign sqrt_done = (state == S_SQRT) && sbit[0];

  logic [63:0] spr_sum;
  assign spr_sum = r_fin + 64'd4;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (fix.data.mode == MODE_ANGLE && depth_ok) state_next = S_LOAD;
          else if (fix.data.mode == MODE_RANGE)        state_next = S_OUT;
        end
      end
      S_LOAD: state_next = S_RED;
      S_RED:  if (red_done) state_next = S_FOLD;
      S_FOLD: state_next = S_ROT;
      S_ROT: begin
        if (rot_last) state_next = (ang_j == 3'd5) ? S_NMUL : S_LOAD;
      end
      S_NMUL: state_next = S_DMUL;
      S_DMUL: state_next = S_DIVC;
      S_DIVC, S_DIV: begin
        if (coord_done)          state_next = (co_r && fix_f == 3'd4) ? S_AXX : S_NMUL;
        else if (state == S_DIVC) state_next = S_DIV;
      end
      S_AXX: state_next = S_AXY;
      S_AXY: state_next = S_SQRT;
      S_TA:  state_next = S_TA2;
      S_TA2: state_next = S_TB;
      S_TB:  state_next = S_TB2;
      S_TB2: state_next = S_SQRT;
      S_SQRT: begin
        if (sqrt_done) begin
          unique case (ph)
            2'd0:    state_next = S_AXX;
            2'd3:    state_next = S_OUT;
            default: state_next = S_TA;
          endcase
        end
      end
      S_OUT: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    fix.ready    = state == S_IDLE;
    result.valid = res_valid;
    result.data  = res_data;
    pready       = 1'b1;
    prdata       = (paddr == REG_DEPTH_FLOOR) ? {16'd0, depth_floor} : 32'd0;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      depth_floor <= DEPTH_FLOOR_RST;
      depth_held  <= DEPTH_RST;
      dvar_held   <= DVAR_RST;
      ang_j       <= '0;
      step_i      <= '0;
      fix_f       <= '0;
      co_r        <= 1'b0;
      div_cnt     <= '0;
      ph          <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) depth_floor <= pwdata[15:0];
      if (accept && fix.data.mode == MODE_DEPTH) begin
        depth_held <= fix.data.depth_mm;
        dvar_held  <= fix.data.depth_variance;
      end
      if (state == S_OUT && slot_free) res_valid <= 1'b1;
      else if (result.ready)           res_valid <= 1'b0;

      // sequencer counters
      if (state == S_IDLE) ang_j <= '0;
      else if (state == S_ROT && rot_last) ang_j <= ang_j + 3'd1;
      if (state == S_FOLD) step_i <= '0;
      else if (state == S_ROT) step_i <= step_i + STEP_W'(1);
      if (state == S_IDLE) begin
        fix_f <= '0;
        co_r  <= 1'b0;
      end else if (coord_done) begin
        co_r <= !co_r;
        if (co_r) fix_f <= fix_f + 3'd1;
      end
      if (state == S_DIVC) div_cnt <= 5'd24;
      else if (state == S_DIV) div_cnt <= div_cnt - 5'd1;
      if (state == S_IDLE) ph <= '0;
      else if (sqrt_done) ph <= ph + 2'd1;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    // capture the item
    if (accept) begin
      b_w     <= $signed({{(AW-16){fix.data.bearing[15]}}, fix.data.bearing}) <<< SHIFT;
      e_w     <= $signed({{(AW-16){fix.data.elevation[15]}}, fix.data.elevation}) <<< SHIFT;
      acc_w   <= $signed({{(AW-14){1'b0}}, fix.data.angle_accuracy}) <<< SHIFT;
      north_r <= fix.data.north;
      east_r  <= fix.data.east;
      up_r    <= fix.data.up;
      racc_r  <= fix.data.range_accuracy;
      rng_r   <= fix.data.mode == MODE_RANGE;
      flag_r  <= 1'b0;
    end

    // angle reduction, fold and rotation
    if (state == S_LOAD) a_r <= ang_sel;
    if (state == S_RED) begin
      if (a_r > PI_W)        a_r <= a_r - TWO_PI_W;
      else if (a_r <= -PI_W) a_r <= a_r + TWO_PI_W;
    end
    if (state == S_FOLD) begin
      cx <= GAIN_Q30;
      cy <= '0;
      if (a_r > HALF_PI_W) begin
        a_r   <= a_r - PI_W;
        neg_r <= 1'b1;
      end else if (a_r < -HALF_PI_W) begin
        a_r   <= a_r + PI_W;
        neg_r <= 1'b1;
      end else begin
        neg_r <= 1'b0;
      end
    end
    if (state == S_ROT) begin
      cx  <= nx;
      cy  <= ny;
      a_r <= (a_r >= 0) ? a_r - atan_w : a_r + atan_w;
      if (rot_last) begin
        sin_r[ang_j] <= 32'(neg_r ? -ny : ny);
        cos_r[ang_j] <= 32'(neg_r ? -nx : nx);
      end
    end

    // coordinate products
    if (state == S_NMUL) n_r   <= 32'(prod >>> 30);
    if (state == S_DMUL) num_r <= 56'(prod);

    // divider
    if (state == S_DIVC) begin
      rem  <= num_abs;
      dsh  <= {den_abs, 24'd0};
      quo  <= '0;
      qneg <= num_neg ^ te_sin[31];
    end
    if (state == S_DIV) begin
      if (div_ge) rem <= rem - dsh;
      dsh <= dsh >> 1;
      quo <= q_fin;
    end
    if (coord_done) begin
      if (co_r) ys[fix_f] <= coord_val;
      else      xs[fix_f] <= coord_val;
      if (coord_sat) flag_r <= 1'b1;
    end

    // axis and spread products, square root load
    if (state == S_AXX) sq_r <= 64'(prod);
    if (state == S_TA || state == S_TB) t_r <= 33'(prod >>> 30);
    if (state == S_TA2) sq_r <= 64'(prod);
    if (state == S_AXY || state == S_TB2) begin
      sv   <= (state == S_AXY) ? (sq_r + 64'(prod)) << 8 : sq_r + 64'(prod);
      sr   <= '0;
      sbit <= 64'd1 << 62;
    end
    if (state == S_SQRT) begin
      if (s_ge) sv <= sv - s_trial;
      sr   <= r_fin;
      sbit <= sbit >> 2;
      if (sbit[0]) begin
        if (ph[1]) spr_r[ph[0]] <= spr_sum[34:3];
        else       ax_r[ph[0]]  <= r_fin[31:0];
      end
    end

    // result register
    if (state == S_OUT && slot_free) begin
      if (rng_r) begin
        res_data.pos_x     <= north_r;
        res_data.pos_y     <= east_r;
        res_data.pos_z     <= up_r;
        res_data.spread_x  <= prod[31:0];
        res_data.spread_y  <= prod[31:0];
        res_data.spread_z  <= prod[31:0];
        res_data.saturated <= 1'b0;
        res_data.source    <= 1'b1;
      end else begin
        res_data.pos_x     <= xs[0];
        res_data.pos_y     <= ys[0];
        res_data.pos_z     <= depth_held;
        res_data.spread_x  <= spr_r[0];
        res_data.spread_y  <= spr_r[1];
        res_data.spread_z  <= dvar_held;
        res_data.saturated <= flag_r;
        res_data.source    <= 1'b0;
      end
    end
  end

  // ---------------- assertions ----------------
  `ACF_ASSERT(a_range_goes_out, accept && fix.data.mode == MODE_RANGE |=> state == S_OUT, "range fix did not go to output")
  `ACF_ASSERT(a_load_from_out, $rose(result.valid) |-> $past(state) == S_OUT, "result loaded outside output state")
  `ACF_ASSERT(a_range_no_sat, result.valid && result.data.source |-> !result.data.saturated, "range result flagged saturated")
  `ACF_ASSERT(a_div_count, state == S_DIV |-> div_cnt <= 5'd24, "divider count out of range")
  `ACF_ASSERT(a_cfg_write, cfg_wr |=> depth_floor == $past(pwdata[15:0]), "depth floor write lost")

endmodule

// ===== bench/tb_acoustic_fix_to_cartesian.sv =====
`timescale 1ns / 1ps

module tb_acoustic_fix_to_cartesian;
  import acf_pkg::*;

  // longest block latency per transaction, plus margin
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES  = 3000;

  typedef struct {
    acf_in_t  item;
    bit       typed;
    bit       none;
    acf_out_t res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  acf_fix_if    fix_ch ();
  acf_result_if res_ch ();

  acoustic_fix_to_cartesian u_dut (
    .clk     (clk),
    .rst     (rst),
    .fix     (fix_ch.sink),
    .result  (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of block state
  logic [15:0] floor_depth;
  longint      depth_store;
  longint      dvar_store;

  acf_out_t    pending_fixes [$];
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          stall_go;
  bit          stall_done;
  int          stall_cnt;
  int          n_err;
  int          n_items;
  int          n_results;
  int          n_sat;
  int          n_range;
  dir_row_t    dir_tab [$];

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #50ms;
    $display("acoustic_fix_to_cartesian verification failed");
    $finish;
  end

  // ---------------- fixed-point predictor ----------------

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rotation CORDIC on a Q30 angle, outputs sin and cos in Q30
  task automatic cordic_sc(input longint ang, output longint s, output longint c);
    longint pi_v;
    longint hpi_v;
    longint tpi_v;
    longint x;
    longint y;
    longint nx;
    longint ny;
    longint at;
    bit     flip;
    pi_v  = longint'(PI_Q30);
    hpi_v = longint'(HALF_PI_Q30);
    tpi_v = longint'(TWO_PI_Q30);
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 1'b0;
    while (ang > pi_v) ang = ang - tpi_v;
    while (ang <= -pi_v) ang = ang + tpi_v;
    // fold into the right half plane
    if (ang > hpi_v) begin
      ang = ang - pi_v;
      flip = 1'b1;
    end else if (ang < -hpi_v) begin
      ang = ang + pi_v;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      at = longint'(ATAN_Q30[i & 31]);
      if (ang >= 0) begin
        nx = x - (y >>> (i & 31));
        ny = y + (x >>> (i & 31));
        ang = ang - at;
      end else begin
        nx = x + (y >>> (i & 31));
        ny = y - (x >>> (i & 31));
        ang = ang + at;
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic longint div_clip(input longint num, input longint den,
                                      inout bit sat);
    longint q;
    if (den == 0) begin
      sat = 1'b1;
      return (num > 0) ? 64'sd8388607 : ((num < 0) ? -64'sd8388608 : 64'sd0);
    end
    q = num / den;
    if (q > 8388607) begin
      sat = 1'b1;
      return 8388607;
    end
    if (q < -8388608) begin
      sat = 1'b1;
      return -8388608;
    end
    return q;
  endfunction

  task automatic fix_to_xy(input longint b, input longint e, output longint px,
                           output longint py, inout bit sat);
    longint sb, cb, se, ce;
    cordic_sc(b, sb, cb);
    cordic_sc(e, se, ce);
    px = div_clip(((sb * ce) >>> 30) * depth_store, se, sat);
    py = div_clip(((cb * ce) >>> 30) * depth_store, se, sat);
  endtask

  function automatic longint unsigned axis_len(input longint x1, input longint y1,
                                               input longint x2, input longint y2);
    longint dx, dy;
    dx = x2 - x1;
    dy = y2 - y1;
    return int_sqrt((longint'(dx * dx) + longint'(dy * dy)) << 8);
  endfunction

  function automatic logic [31:0] ellipse_spread(input longint a, input longint sa,
                                                 input longint b, input longint sb,
                                                 inout bit sat);
    longint ta, tb;
    longint unsigned r;
    ta = (a * sa) >>> 30;
    tb = (b * sb) >>> 30;
    r = (int_sqrt(longint'(ta * ta) + longint'(tb * tb)) + 4) >> 3;
    if (r > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      r = 64'hFFFF_FFFF;
    end
    return r[31:0];
  endfunction

  // advance predictor state by one fix; returns 1 when a result is due
  task automatic project_fix(input acf_in_t it, output bit due, output acf_out_t r);
    longint scl, b, e, acc;
    longint x, y, x11, y11, x12, y12, x21, y21, x22, y22, sb, cb;
    longint unsigned ax1, ax2, la, lb;
    logic [31:0] v;
    bit sat;
    due = 1'b0;
    r = '0;
    sat = 1'b0;
    scl = 64'sd1 << (30 - ANGLE_FRAC_BITS_DEF);
    case (it.mode)
      MODE_DEPTH: begin
        depth_store = longint'(it.depth_mm);
        dvar_store = longint'({32'd0, it.depth_variance});
      end
      MODE_RANGE: begin
        v = it.range_accuracy * it.range_accuracy;
        r = '{it.north, it.east, it.up, v, v, v, 1'b0, 1'b1};
        due = 1'b1;
      end
      MODE_ANGLE: begin
        if (depth_store >= longint'({48'd0, floor_depth})) begin
          b = longint'(it.bearing) * scl;
          e = longint'(it.elevation) * scl;
          acc = longint'({50'd0, it.angle_accuracy}) * scl;
          fix_to_xy(b, e, x, y, sat);
          fix_to_xy(b, e + acc, x11, y11, sat);
          fix_to_xy(b, e - acc, x12, y12, sat);
          fix_to_xy(b + acc, e, x21, y21, sat);
          fix_to_xy(b - acc, e, x22, y22, sat);
          ax1 = axis_len(x11, y11, x12, y12);
          ax2 = axis_len(x21, y21, x22, y22);
          la = (ax1 > ax2) ? ax1 : ax2;
          lb = (ax1 > ax2) ? ax2 : ax1;
          cordic_sc(b, sb, cb);
          r.spread_x = ellipse_spread(la, sb, lb, cb, sat);
          r.spread_y = ellipse_spread(la, cb, lb, sb, sat);
          r.pos_x = x[23:0];
          r.pos_y = y[23:0];
          r.pos_z = depth_store[23:0];
          r.spread_z = dvar_store[31:0];
          r.saturated = sat;
          r.source = 1'b0;
          due = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic acf_in_t mk_fix(input logic [1:0] md, input int b, input int e,
                                     input int acc, input int d, input int unsigned dv,
                                     input int n, input int ea, input int u,
                                     input int ra);
    acf_in_t it;
    it.mode = md;
    it.bearing = b[15:0];
    it.elevation = e[15:0];
    it.angle_accuracy = acc[13:0];
    it.depth_mm = d[23:0];
    it.depth_variance = dv;
    it.north = n[23:0];
    it.east = ea[23:0];
    it.up = u[23:0];
    it.range_accuracy = ra[15:0];
    return it;
  endfunction

  function automatic void add_row(input acf_in_t it, input bit typed, input bit none,
                                  input acf_out_t res);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.none = none;
    row.res = res;
    dir_tab.push_back(row);
  endfunction

  function automatic int pick_angle();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(24000) - 12000;
    if (sel < 90) return $urandom_range(65535) - 32768;
    return (sel < 95) ? 0 : 25736;
  endfunction

  function automatic acf_in_t rand_fix();
    acf_in_t it;
    int sel;
    it = acf_in_t'(192'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom}));
    sel = $urandom_range(99);
    if (sel < 25) it.mode = MODE_DEPTH;
    else if (sel < 65) it.mode = MODE_ANGLE;
    else if (sel < 95) it.mode = MODE_RANGE;
    else it.mode = 2'd3;
    it.bearing = 16'(pick_angle());
    it.elevation = 16'(pick_angle());
    sel = $urandom_range(99);
    if (sel < 70) it.angle_accuracy = 14'($urandom_range(800));
    else if (sel < 80) it.angle_accuracy = 14'd0;
    else if (sel < 85) it.angle_accuracy = 14'd8192;
    // depth: mostly plausible, some huge, some negative
    sel = $urandom_range(99);
    if (sel < 55) it.depth_mm = 24'($urandom_range(60000, 50));
    else if (sel < 75) it.depth_mm = 24'($urandom_range(400000, 65535));
    else if (sel < 85) it.depth_mm = -24'sd1 * 24'($urandom_range(5000));
    return it;
  endfunction

  // ---------------- transaction drivers ----------------

  task automatic send_fix(input acf_in_t it);
    bit due;
    acf_out_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      fix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    fix_ch.valid <= 1'b1;
    fix_ch.data <= it;
    @(posedge clk);
    while (!fix_ch.ready) @(posedge clk);
    n_items++;
    project_fix(it, due, r);
    if (due) pending_fixes.push_back(r);
  endtask

  task automatic drain_block();
    fix_ch.valid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth_floor(input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_DEPTH_FLOOR;
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    floor_depth = val;
  endtask

  task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) send_fix(rand_fix());
    drain_block();
  endtask

  // ---------------- result checker ----------------

  always @(posedge clk) begin
    acf_out_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (res_ch.data.saturated) n_sat++;
      if (res_ch.data.source) n_range++;
      if (pending_fixes.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result transaction: %p", res_ch.data);
      end else begin
        want = pending_fixes.pop_front();
        if (res_ch.data.pos_x !== want.pos_x || res_ch.data.pos_y !== want.pos_y ||
            res_ch.data.pos_z !== want.pos_z || res_ch.data.spread_x !== want.spread_x ||
            res_ch.data.spread_y !== want.spread_y ||
            res_ch.data.spread_z !== want.spread_z ||
            res_ch.data.saturated !== want.saturated ||
            res_ch.data.source !== want.source) begin
          n_err++;
          if (n_err <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  exp %p", want);
            $display("  got %p", res_ch.data);
          end
        end
      end
    end
    // long hold-off once, so the block fills and stalls its input
    if (stall_go && !stall_done) begin
      res_ch.ready <= 1'b0;
      stall_cnt++;
      if (stall_cnt >= HOLD_CYCLES) stall_done = 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    bit due;
    acf_out_t r;
    acf_out_t none_res;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fix_ch.valid = 1'b0;
    fix_ch.data = '0;
    res_ch.ready = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_go = 1'b0;
    stall_done = 1'b0;
    stall_cnt = 0;
    n_err = 0;
    n_items = 0;
    n_results = 0;
    n_sat = 0;
    n_range = 0;
    floor_depth = DEPTH_FLOOR_RST;
    depth_store = longint'(DEPTH_RST);
    dvar_store = longint'({32'd0, DVAR_RST});
    none_res = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    add_row(mk_fix(MODE_ANGLE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, none_res);
    add_row(mk_fix(MODE_RANGE, 0, 0, 0, 0, 0, 8388607, -8388608, 0, 65535), 1, 0,
            '{24'sh7FFFFF, 24'sh800000, 24'sd0, 32'd4294836225, 32'd4294836225,
              32'd4294836225, 1'b0, 1'b1});
    add_row(mk_fix(MODE_RANGE, 0, 0, 0, 0, 0, 0, 0, -8388608, 0), 1, 0,
            '{24'sd0, 24'sd0, 24'sh800000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1});
    add_row(mk_fix(2'd3, 100, 100, 10, 5, 5, 1, 1, 1, 1), 1, 1, none_res);
    add_row(mk_fix(MODE_ANGLE, 1000, 4000, 200, 0, 0, 0, 0, 0, 0), 0, 0, none_res);
    add_row(mk_fix(MODE_DEPTH, 0, 0, 0, 50, 7, 0, 0, 0, 0), 1, 1, none_res);
    add_row(mk_fix(MODE_ANGLE, 1000, 4000, 200, 0, 0, 0, 0, 0, 0), 1, 1, none_res);
    add_row(mk_fix(MODE_DEPTH, 0, 0, 0, -5, 0, 0, 0, 0, 0), 1, 1, none_res);
    add_row(mk_fix(MODE_ANGLE, 1000, 4000, 200, 0, 0, 0, 0, 0, 0), 1, 1, none_res);
    add_row(mk_fix(MODE_DEPTH, 0, 0, 0, 8388607, 32'hFFFF_FFFF, 0, 0, 0, 0), 1, 1,
            none_res);
    add_row(mk_fix(MODE_ANGLE, 32767, -32768, 8192, 0, 0, 0, 0, 0, 0), 0, 0, none_res);
    add_row(mk_fix(MODE_ANGLE, -32768, 32767, 16383, 0, 0, 0, 0, 0, 0), 0, 0, none_res);
    add_row(mk_fix(MODE_ANGLE, 500, 25736, 100, 0, 0, 0, 0, 0, 0), 0, 0, none_res);
    add_row(mk_fix(MODE_DEPTH, 0, 0, 0, -8388608, 0, 0, 0, 0, 0), 1, 1, none_res);
    add_row(mk_fix(MODE_ANGLE, 0, 4000, 0, 0, 0, 0, 0, 0, 0), 1, 1, none_res);
    add_row(mk_fix(MODE_DEPTH, 0, 0, 0, 100, 12345, 0, 0, 0, 0), 1, 1, none_res);
    add_row(mk_fix(MODE_ANGLE, 6434, 4000, 100, 0, 0, 0, 0, 0, 0), 0, 0, none_res);
    add_row(mk_fix(MODE_ANGLE, -12868, 12868, 300, 0, 0, 0, 0, 0, 0), 0, 0, none_res);
    add_row(mk_fix(MODE_DEPTH, 0, 0, 0, 20000, 400, 0, 0, 0, 0), 1, 1, none_res);
    add_row(mk_fix(MODE_ANGLE, 3000, 1, 50, 0, 0, 0, 0, 0, 0), 0, 0, none_res);

    foreach (dir_tab[i]) begin
      fix_ch.valid <= 1'b1;
      fix_ch.data <= dir_tab[i].item;
      @(posedge clk);
      while (!fix_ch.ready) @(posedge clk);
      n_items++;
      project_fix(dir_tab[i].item, due, r);
      if (dir_tab[i].typed) begin
        if (!dir_tab[i].none) pending_fixes.push_back(dir_tab[i].res);
      end else if (due) begin
        pending_fixes.push_back(r);
      end
    end
    drain_block();

    // random phases over several thresholds, including both extremes
    write_depth_floor(16'd0);
    stall_go = 1'b1;
    run_phase(600, 37, 73);
    write_depth_floor(16'hFFFF);
    run_phase(550, 73, 37);
    write_depth_floor(16'($urandom_range(3000, 1)));
    run_phase(580, 0, 0);

    $display("covered %0d fix transactions, %0d results (%0d range, %0d saturated)",
             n_items, n_results, n_range, n_sat);
    $display("depth floor swept 100, 0, 65535 and a random value; one long result stall");
    if (n_err == 0 && pending_fixes.size() == 0) begin
      $display("acoustic_fix_to_cartesian verification clean");
    end else begin
      $display("%0d mismatches, %0d results still owed", n_err, pending_fixes.size());
      $display("acoustic_fix_to_cartesian verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/acf_pkg.sv
rtl/acf_if.sv
rtl/acoustic_fix_to_cartesian.sv
bench/tb_acoustic_fix_to_cartesian.sv
